// ===== src/gld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_pkg
// Shared types and constants for the gyro lowpass decimator.
// ----------------------------------------------------------------------------
package gld_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int RES_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int COEF_W     = 18;
  localparam int DELAY_W    = 32;
  localparam int FSUM_W     = 32;
  localparam int RSUM_W     = 24;
  localparam int GAIN_FRAC  = 16;
  localparam int OUT_FRAC   = 8;
  localparam int LAST_STEP  = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_PT1_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LPF_B0       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LPF_A1       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LPF_A2       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM_RATIO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_SCALE    = 3'd5;
  // no register lives at this index
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG       = 3'd7;

  typedef enum logic [2:0] {
    MO_IDLE, MO_GAIN, MO_B0, MO_A1, MO_A2, MO_FSUM, MO_RSUM
  } mul_op_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_S, ACT_Y, ACT_D1, ACT_D2, ACT_OUTF, ACT_OUTR
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FILT, ST_CHECK, ST_WAIT, ST_EMIT
  } state_t;

  typedef struct packed {
    logic       load;
    mul_op_t    mul_op;
    logic [1:0] mul_axis;
    act_t       act;
    logic [1:0] act_axis;
    logic       count;
    logic       clear_cnt;
    logic       out_set;
  } cmd_t;

  typedef struct packed {
    logic due;
    logic out_full;
  } sts_t;

endpackage

// ===== src/gld_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_if
// Channel interfaces: sample input, result output, configuration write.
// ----------------------------------------------------------------------------
interface gld_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_sample;
  logic signed [15:0] y_sample;
  logic signed [15:0] z_sample;
  modport source (output valid, x_sample, y_sample, z_sample, input ready);
  modport sink (input valid, x_sample, y_sample, z_sample, output ready);
endinterface

interface gld_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] filt_x;
  logic signed [23:0] filt_y;
  logic signed [23:0] filt_z;
  logic signed [23:0] raw_x;
  logic signed [23:0] raw_y;
  logic signed [23:0] raw_z;
  modport source (output valid, filt_x, filt_y, filt_z, raw_x, raw_y, raw_z,
                  input ready);
  modport sink (input valid, filt_x, filt_y, filt_z, raw_x, raw_y, raw_z,
                output ready);
endinterface

interface gld_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [17:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/gld_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_ctrl
// Sequencer: steps the shared multiplier through three axes, checks the decimation count, then emits when due.
// ----------------------------------------------------------------------------
module gld_ctrl
  import gld_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state, state_next;
  logic [2:0] step, step_next;
  logic [1:0] axis, axis_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    axis_next  = axis;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_FILT;
          step_next  = '0;
          axis_next  = '0;
        end
      end
      ST_FILT: begin
        if (step == 3'(LAST_STEP)) begin
          step_next = '0;
          if (axis == 2'd2) state_next = ST_CHECK;
          else axis_next = axis + 2'd1;
        end else begin
          step_next = step + 3'd1;
        end
      end
      ST_CHECK: state_next = sts.due ? ST_WAIT : ST_IDLE;
      ST_WAIT: begin
        if (!sts.out_full) begin
          state_next = ST_EMIT;
          step_next  = '0;
        end
      end
      ST_EMIT: begin
        if (step == 3'(LAST_STEP)) state_next = ST_IDLE;
        else step_next = step + 3'd1;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [2:0] j;
    j        = step - 3'd1;
    in_ready = 1'b0;
    cmd      = '{load: 1'b0, mul_op: MO_IDLE, mul_axis: 2'd0, act: ACT_NONE,
                 act_axis: 2'd0, count: 1'b0, clear_cnt: 1'b0, out_set: 1'b0};
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_FILT: begin
        cmd.mul_axis = axis;
        cmd.act_axis = axis;
        unique case (step)
          3'd0: cmd.mul_op = MO_GAIN;
          3'd1: cmd.act = ACT_S;
          3'd2: cmd.mul_op = MO_B0;
          3'd3: cmd.act = ACT_Y;
          3'd4: cmd.mul_op = MO_A1;
          3'd5: begin
            cmd.act    = ACT_D1;
            cmd.mul_op = MO_A2;
          end
          3'd6: begin
            cmd.act   = ACT_D2;
            cmd.count = (axis == 2'd2);
          end
          default: cmd.act = ACT_NONE;
        endcase
      end
      ST_EMIT: begin
        // multiply for slot k while the product of slot k-1 is written out
        if (step < 3'd3) begin
          cmd.mul_op   = MO_FSUM;
          cmd.mul_axis = step[1:0];
        end else if (step < 3'(LAST_STEP)) begin
          cmd.mul_op   = MO_RSUM;
          cmd.mul_axis = 2'(step - 3'd3);
        end
        if (step != 3'd0) begin
          if (j < 3'd3) begin
            cmd.act      = ACT_OUTF;
            cmd.act_axis = j[1:0];
          end else begin
            cmd.act      = ACT_OUTR;
            cmd.act_axis = 2'(j - 3'd3);
          end
        end
        if (step == 3'(LAST_STEP)) begin
          cmd.out_set   = 1'b1;
          cmd.clear_cnt = 1'b1;
        end
      end
      default: cmd.load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      axis  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      axis  <= axis_next;
    end
  end

  a_out_set_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_set |-> !sts.out_full) else $error("result written over a full output");
  a_out_set_full: assert property (@(posedge clk) disable iff (rst)
    cmd.out_set |=> sts.out_full) else $error("result not presented");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_FILT && step == 3'd0 && axis == 2'd0))
    else $error("accepted transaction not started");

endmodule

// ===== src/gld_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_datapath
// Registers, filter state, shared multiplier and output register.
// ----------------------------------------------------------------------------
module gld_datapath
  import gld_pkg::*;
#(
  parameter int FRAC_BITS      = 8,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  gld_cfg_if.sink                    cfg,
  input  logic signed [SAMPLE_W-1:0] x_sample,
  input  logic signed [SAMPLE_W-1:0] y_sample,
  input  logic signed [SAMPLE_W-1:0] z_sample,
  gld_out_if.source                  result,
  input  cmd_t                       cmd,
  output sts_t                       sts
);

  localparam int DW = SAMPLE_W + FRAC_BITS;
  localparam int AW = (DW + 1 > DELAY_W) ? DW + 1 : DELAY_W;
  localparam int PW = AW + COEF_W;
  localparam int EW = PW + 2;

  logic [15:0]              gain, b0, scale;
  logic signed [17:0]       a1;
  logic signed [16:0]       a2;
  logic [7:0]               decim, cnt;

  logic signed [SAMPLE_W-1:0] x_q [3];
  logic signed [DW-1:0]       s_q [3];
  logic signed [DELAY_W-1:0]  d1_q [3];
  logic signed [DELAY_W-1:0]  d2_q [3];
  logic signed [FSUM_W-1:0]   fsum_q [3];
  logic signed [RSUM_W-1:0]   rsum_q [3];
  logic signed [RES_W-1:0]    outf_q [3];
  logic signed [RES_W-1:0]    outr_q [3];
  logic signed [DW-1:0]       y_q;
  logic signed [PW-1:0]       pb_q, prod_q;
  logic                       out_full;

  logic signed [AW-1:0]     mul_a;
  logic signed [COEF_W-1:0] mul_b;
  logic signed [DW-1:0]     xf;
  logic [7:0]               fac;

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] hi, lo;
    hi = EW'({1'b0, {(DW-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return {1'b0, {(DW-1){1'b1}}};
    else if (v < lo) return {1'b1, {(DW-1){1'b0}}};
    else return v[DW-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] hi, lo;
    hi = EW'({1'b0, {31{1'b1}}});
    lo = ~hi;
    if (v > hi) return {1'b0, {31{1'b1}}};
    else if (v < lo) return {1'b1, {31{1'b0}}};
    else return v[31:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] hi, lo;
    hi = EW'({1'b0, {23{1'b1}}});
    lo = ~hi;
    if (v > hi) return {1'b0, {23{1'b1}}};
    else if (v < lo) return {1'b1, {23{1'b0}}};
    else return v[23:0];
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain  <= 16'hFFFF;
      b0    <= 16'h4000;
      a1    <= '0;
      a2    <= '0;
      decim <= 8'd1;
      scale <= 16'hFFFF;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_PT1_GAIN:     gain  <= cfg.data[15:0];
        CFG_LPF_B0:       b0    <= cfg.data[15:0];
        CFG_LPF_A1:       a1    <= signed'(cfg.data);
        CFG_LPF_A2:       a2    <= signed'(cfg.data[16:0]);
        CFG_DECIM_RATIO:  decim <= cfg.data[7:0];
        CFG_OUT_SCALE:    scale <= cfg.data[15:0];
        default:          gain  <= gain;
      endcase
    end
  end

  assign xf = {x_q[cmd.mul_axis], {FRAC_BITS{1'b0}}};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      MO_GAIN: begin
        mul_a = AW'(xf) - AW'(s_q[cmd.mul_axis]);
        mul_b = signed'({2'b00, gain});
      end
      MO_B0: begin
        mul_a = AW'(s_q[cmd.mul_axis]);
        mul_b = signed'({2'b00, b0});
      end
      MO_A1: begin
        mul_a = AW'(y_q);
        mul_b = a1;
      end
      MO_A2: begin
        mul_a = AW'(y_q);
        mul_b = COEF_W'(a2);
      end
      MO_FSUM: begin
        mul_a = AW'(fsum_q[cmd.mul_axis]);
        mul_b = signed'({2'b00, scale});
      end
      MO_RSUM: begin
        mul_a = AW'(rsum_q[cmd.mul_axis]);
        mul_b = signed'({2'b00, scale});
      end
      default: mul_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_q[0] <= x_sample;
      x_q[1] <= y_sample;
      x_q[2] <= z_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        s_q[i]    <= '0;
        d1_q[i]   <= '0;
        d2_q[i]   <= '0;
        fsum_q[i] <= '0;
        rsum_q[i] <= '0;
      end
    end else begin
      unique case (cmd.act)
        ACT_S: s_q[cmd.act_axis] <=
          sat_dw(EW'(s_q[cmd.act_axis]) + EW'(prod_q >>> GAIN_FRAC));
        ACT_Y: begin
          pb_q <= prod_q;
          y_q  <= sat_dw(EW'(prod_q >>> COEF_FRAC_BITS) + EW'(d1_q[cmd.act_axis]));
        end
        ACT_D1: d1_q[cmd.act_axis] <=
          sat32((((EW'(pb_q) <<< 1) - EW'(prod_q)) >>> COEF_FRAC_BITS)
                + EW'(d2_q[cmd.act_axis]));
        ACT_D2: begin
          d2_q[cmd.act_axis]   <= sat32((EW'(pb_q) - EW'(prod_q)) >>> COEF_FRAC_BITS);
          fsum_q[cmd.act_axis] <= sat32(EW'(fsum_q[cmd.act_axis]) + EW'(y_q));
          rsum_q[cmd.act_axis] <= sat24(EW'(rsum_q[cmd.act_axis])
                                        + EW'(x_q[cmd.act_axis]));
        end
        ACT_OUTF: begin
          outf_q[cmd.act_axis] <=
            sat24(EW'(prod_q >>> (GAIN_FRAC + FRAC_BITS - OUT_FRAC)));
          fsum_q[cmd.act_axis] <= '0;
        end
        ACT_OUTR: begin
          outr_q[cmd.act_axis] <= sat24(EW'(prod_q >>> (GAIN_FRAC - OUT_FRAC)));
          rsum_q[cmd.act_axis] <= '0;
        end
        default: pb_q <= pb_q;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      out_full <= 1'b0;
    end else begin
      if (cmd.clear_cnt) cnt <= '0;
      else if (cmd.count) cnt <= cnt + 8'd1;
      if (cmd.out_set) out_full <= 1'b1;
      else if (result.ready) out_full <= 1'b0;
    end
  end

  // a zero factor behaves as one
  assign fac          = (decim == 8'd0) ? 8'd1 : decim;
  assign sts.due      = (cnt >= fac);
  assign sts.out_full = out_full;

  assign result.valid  = out_full;
  assign result.filt_x = outf_q[0];
  assign result.filt_y = outf_q[1];
  assign result.filt_z = outf_q[2];
  assign result.raw_x  = outr_q[0];
  assign result.raw_y  = outr_q[1];
  assign result.raw_z  = outr_q[2];

endmodule

// ===== src/gyro_lowpass_decimator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_lowpass_decimator_core
// Per-axis first-order and biquad lowpass with block-average decimation.
// ----------------------------------------------------------------------------
// Usage:
//   sample : valid/ready channel, one three-axis gyro sample per transaction.
//   result : valid/ready channel, six Q15.8 averages once per decimation block.
//   cfg    : valid/ready write channel (index, data), always ready; write only
//            while the block is idle.
// Sequence: a sample is taken in the idle state, then the shared multiplier runs
//   seven steps per axis and the block makes the decimation check before the
//   next sample can be taken. A sample that completes a block adds a wait state
//   and seven emit steps (six scaling products); the result is valid from the
//   cycle in which the next sample can be taken.
// The result sits in an output register; the next sample is accepted while it
//   waits. If the receiver stalls and another result is due, the block holds
//   in its wait state until the register is free.
// Reset clears all filter state, sums, counter and loads register defaults.
// ----------------------------------------------------------------------------
module gyro_lowpass_decimator_core
  import gld_pkg::*;
#(
  parameter int FRAC_BITS      = 8,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  gld_in_if.sink    sample,
  gld_out_if.source result,
  gld_cfg_if.sink   cfg
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign sample.ready = in_ready;

  gld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gld_datapath #(
    .FRAC_BITS      (FRAC_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .x_sample (sample.x_sample),
    .y_sample (sample.y_sample),
    .z_sample (sample.z_sample),
    .result   (result),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ===== tb/gld_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gld_checker
// Watches the sample, config and result channels, predicts every result from
// the accepted samples and register writes, and compares each field.
// ----------------------------------------------------------------------------
module gld_checker
  import gld_pkg::*;
(
  input  logic clk,
  input  logic rst,
  gld_in_if    sample,
  gld_out_if   result,
  gld_cfg_if   cfg,
  output int   fail_count,
  output int   pending,
  output int   result_count
);

  localparam int FB    = 8;
  localparam int CB    = 16;
  localparam int DATAW = 16 + FB;

  typedef struct {
    logic signed [23:0] filt [3];
    logic signed [23:0] raw [3];
  } avg_t;

  avg_t avg_q[$];

  logic [15:0] gain, b0, scale;
  logic [7:0]  decim;
  longint      a1, a2;
  longint      pt1_val [3];
  longint      dly [6];
  longint      fsum [3];
  longint      rsum [3];
  int          count;

  function automatic longint clip(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  task automatic report(string what, int axis, longint got, longint want);
    $display("mismatch %s[%0d]: got %0d expected %0d at %0t", what, axis, got, want,
             $realtime);
    fail_count++;
  endtask

  task automatic filter_sample(longint smp [3]);
    longint xf, s, y, d1, d2;
    avg_t a;
    int fac;
    fac = decim == 0 ? 1 : decim;
    for (int i = 0; i < 3; i++) begin
      xf = smp[i] <<< FB;
      s = clip(pt1_val[i] + ((longint'(gain) * (xf - pt1_val[i])) >>> 16), DATAW);
      pt1_val[i] = s;
      y = clip(((longint'(b0) * s) >>> CB) + dly[2*i], DATAW);
      d1 = clip(((2 * longint'(b0) * s - a1 * y) >>> CB) + dly[2*i+1], 32);
      d2 = clip((longint'(b0) * s - a2 * y) >>> CB, 32);
      dly[2*i] = d1;
      dly[2*i+1] = d2;
      fsum[i] = clip(fsum[i] + y, 32);
      rsum[i] = clip(rsum[i] + smp[i], 24);
    end
    count = (count + 1) & 8'hff;
    if (count >= fac) begin
      for (int i = 0; i < 3; i++) begin
        a.filt[i] = clip((fsum[i] * longint'(scale)) >>> (16 + FB - OUT_FRAC), 24);
        a.raw[i] = clip((rsum[i] * longint'(scale)) >>> (16 - OUT_FRAC), 24);
        fsum[i] = 0;
        rsum[i] = 0;
      end
      count = 0;
      avg_q.push_back(a);
    end
  endtask

  always @(posedge clk) begin
    longint smp [3];
    avg_t e;
    if (rst) begin
      gain = 16'hffff; b0 = 16384; a1 = 0; a2 = 0; decim = 1; scale = 16'hffff;
      for (int i = 0; i < 3; i++) begin
        pt1_val[i] = 0; fsum[i] = 0; rsum[i] = 0; dly[2*i] = 0; dly[2*i+1] = 0;
      end
      count = 0;
      avg_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_PT1_GAIN:     gain = cfg.data[15:0];
          CFG_LPF_B0:       b0 = cfg.data[15:0];
          CFG_LPF_A1:       a1 = longint'(signed'(cfg.data[17:0]));
          CFG_LPF_A2:       a2 = longint'(signed'(cfg.data[16:0]));
          CFG_DECIM_RATIO:  decim = cfg.data[7:0];
          CFG_OUT_SCALE:    scale = cfg.data[15:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        result_count++;
        if (avg_q.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          fail_count++;
        end else begin
          e = avg_q.pop_front();
          if (result.filt_x !== e.filt[0]) report("filt", 0, result.filt_x, e.filt[0]);
          if (result.filt_y !== e.filt[1]) report("filt", 1, result.filt_y, e.filt[1]);
          if (result.filt_z !== e.filt[2]) report("filt", 2, result.filt_z, e.filt[2]);
          if (result.raw_x !== e.raw[0]) report("raw", 0, result.raw_x, e.raw[0]);
          if (result.raw_y !== e.raw[1]) report("raw", 1, result.raw_y, e.raw[1]);
          if (result.raw_z !== e.raw[2]) report("raw", 2, result.raw_z, e.raw[2]);
        end
      end
      if (sample.valid && sample.ready) begin
        smp[0] = sample.x_sample;
        smp[1] = sample.y_sample;
        smp[2] = sample.z_sample;
        filter_sample(smp);
      end
    end
    pending = avg_q.size();
  end

endmodule

// ===== tb/gyro_lowpass_decimator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_lowpass_decimator_core_tb
// Drives gyro samples and register settings through several phases of
// sender and receiver idling; a checker module predicts and compares results.
// ----------------------------------------------------------------------------
module gyro_lowpass_decimator_core_tb;
  import gld_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending, result_count;
  int   send_idle, recv_stall;
  int   sample_count;

  gld_in_if  sample ();
  gld_out_if result ();
  gld_cfg_if cfg ();

  gyro_lowpass_decimator_core dut (
    .clk(clk), .rst(rst), .sample(sample), .result(result), .cfg(cfg)
  );

  gld_checker chk (
    .clk(clk), .rst(rst), .sample(sample), .result(result), .cfg(cfg),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  always #5 clk = ~clk;

  initial begin
    sample.valid = 0;
    sample.x_sample = 0;
    sample.y_sample = 0;
    sample.z_sample = 0;
    cfg.valid = 0;
    cfg.index = 0;
    cfg.data = 0;
    result.ready = 0;
  end

  // receiver stalls at the phase's rate
  always @(posedge clk) result.ready <= ($urandom_range(99) >= recv_stall);

  // valid stays high after the handshake; the next call drops it only while it idles, drain drops it
  task automatic send(logic signed [15:0] x, logic signed [15:0] y,
                      logic signed [15:0] z);
    while ($urandom_range(99) < send_idle) begin
      sample.valid <= 0;
      @(posedge clk);
    end
    sample.valid <= 1;
    sample.x_sample <= x;
    sample.y_sample <= y;
    sample.z_sample <= z;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    sample_count++;
  endtask

  task automatic drain();
    sample.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [17:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rnd_sample(int kind);
    case (kind)
      0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1: return $signed(16'($urandom_range(511))) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic setup(int p);
    write_reg(CFG_PT1_GAIN, p == 0 ? 18'hffff : 18'($urandom_range(65535)));
    write_reg(CFG_LPF_B0, p == 1 ? 18'hffff : (p == 2 ? 18'd0 :
              18'($urandom_range(40000))));
    write_reg(CFG_LPF_A1, p == 1 ? 18'h20000 : (p == 2 ? 18'h1ffff :
              18'($urandom)));
    write_reg(CFG_LPF_A2, p == 1 ? 18'h10000 : (p == 2 ? 18'h0ffff :
              18'($urandom)));
    write_reg(CFG_DECIM_RATIO, p == 1 ? 18'd255 : (p == 2 ? 18'd0 :
              18'($urandom_range(1, 12))));
    write_reg(CFG_OUT_SCALE, p == 2 ? 18'd0 : 18'($urandom));
    write_reg(CFG_NO_REG, 18'($urandom));   // out-of-range index, ignored
  endtask

  initial begin
    int kind;
    send_idle = 0;
    recv_stall = 0;
    sample_count = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: defaults, extremes, saturation
    send(16'sh7fff, 16'sh8000, 16'sd0);
    send(16'sh8000, 16'sh7fff, 16'sd1);
    send(-16'sd1, 16'sd0, 16'sh7fff);
    drain();
    write_reg(CFG_DECIM_RATIO, 18'd4);
    for (int i = 0; i < 8; i++) send(16'sh7fff, 16'sh8000, 16'sh7fff);
    drain();
    write_reg(CFG_DECIM_RATIO, 18'd0);   // zero treated as one
    send(16'sd100, -16'sd100, 16'sd5);
    drain();
    write_reg(CFG_DECIM_RATIO, 18'd6);
    send(16'sd7, 16'sd7, 16'sd7);
    send(16'sd7, 16'sd7, 16'sd7);
    send(16'sd7, 16'sd7, 16'sd7);
    drain();
    write_reg(CFG_DECIM_RATIO, 18'd2);   // lowered mid-block: counter kept
    send(16'sd9, 16'sd9, 16'sd9);
    drain();
    write_reg(CFG_LPF_A1, 18'h20000);     // unstable, saturation bounds it
    write_reg(CFG_LPF_A2, 18'h0ffff);
    write_reg(CFG_LPF_B0, 18'hffff);
    for (int i = 0; i < 6; i++) send(16'sh7fff, 16'sh8000, 16'sh7fff);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 69; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 69; end
        default: begin send_idle = 15; recv_stall = 15; end
      endcase
      setup(ph < 3 ? ph : 3);
      for (int i = 0; i < 172; i++) begin
        kind = $urandom_range(9) == 0 ? 0 : ($urandom_range(2) == 0 ? 1 : 2);
        send(rnd_sample(kind), rnd_sample(kind), rnd_sample(kind));
        if (i == 86 && ph == 2) drain();   // sender waits for every result
      end
      drain();
    end

    $display("covered %0d samples, %0d results over 8 register settings",
             sample_count, result_count);
    if (fail_count == 0) begin
      $display("** gyro_lowpass_decimator_core: PASSED **");
    end else begin
      $display("** gyro_lowpass_decimator_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** gyro_lowpass_decimator_core: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/gld_pkg.sv
src/gld_if.sv
src/gld_ctrl.sv
src/gld_datapath.sv
src/gyro_lowpass_decimator_core.sv
tb/gld_checker.sv
tb/gyro_lowpass_decimator_core_tb.sv
